>>> rtl/bdrl_pkg.sv
package bdrl_pkg;

	localparam int UNITS = 256;
	localparam int ALPHABET = 256;
	localparam int WEIGHT_FRAC_BITS = 20;

	localparam int UNIT_W = $clog2(UNITS);
	localparam int BYTE_W = $clog2(ALPHABET);
	localparam int ADDR_W = UNIT_W + BYTE_W;
	localparam int W_W = 24;
	localparam int ACC_W = 32;
	localparam int TOT_W = 40;
	localparam int NS_W = 31;
	localparam int RATE_W = 16;
	localparam int GAIN_W = 24;
	localparam int CFG_IDX_W = 8;

	localparam logic signed [W_W:0] W_ONE = (W_W + 1)'(1 << WEIGHT_FRAC_BITS);
	localparam logic signed [W_W+9:0] W_MAX = (W_W + 10)'(5 * (1 << WEIGHT_FRAC_BITS));

	localparam logic [1:0] MODE_LEARN = 2'd0;
	localparam logic [1:0] MODE_SCORE = 2'd1;
	localparam logic [1:0] MODE_EMPTY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TWO_STORES = CFG_IDX_W'(1);

	typedef struct packed {
		logic              load;
		logic              issue;
		logic [BYTE_W-1:0] byte_idx;
		logic              clear_we;
		logic [ADDR_W-1:0] clear_addr;
		logic              acc_reset;
		logic              out_load;
	} cmd_t;

	typedef struct packed {
		logic busy;
	} sts_t;

endpackage

>>> rtl/bdrl_if.sv
interface bdrl_in_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          mode;
	logic                                store_sel;
	logic [7:0]                          unit;
	logic [7:0]                          next_byte;
	logic signed [bdrl_pkg::GAIN_W-1:0]  local_gain;
	logic                                also_second;
	logic                                last;

	modport source (output valid, mode, store_sel, unit, next_byte, local_gain,
		also_second, last, input ready);
	modport sink (input valid, mode, store_sel, unit, next_byte, local_gain,
		also_second, last, output ready);
endinterface

interface bdrl_out_if;
	logic                        valid;
	logic                        ready;
	logic [bdrl_pkg::NS_W-1:0]   next_score;
	logic [bdrl_pkg::TOT_W-1:0]  total_score;

	modport source (output valid, next_score, total_score, input ready);
	modport sink (input valid, next_score, total_score, output ready);
endinterface

interface bdrl_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bdrl_pkg::CFG_IDX_W-1:0]  index;
	logic [bdrl_pkg::RATE_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/bdrl_ctrl.sv
module bdrl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic [1:0]           item_mode,
	input  logic                 item_last,
	output logic                 item_ready,
	input  logic                 res_ready,
	output logic                 res_valid,
	input  bdrl_pkg::sts_t       sts,
	output bdrl_pkg::cmd_t       cmd
);
	import bdrl_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]        state_q;
	logic [BYTE_W-1:0] byte_q;
	logic [ADDR_W-1:0] clr_q;
	logic              emit_q;
	logic              res_valid_q;
	logic              accept;
	logic              out_free;

	assign item_ready = (state_q == ST_IDLE);
	assign accept = item_valid && item_ready;
	assign out_free = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;

	always_comb begin
		cmd = '0;
		cmd.byte_idx = byte_q;
		cmd.clear_addr = clr_q;
		cmd.clear_we = (state_q == ST_CLEAR);
		cmd.load = accept;
		cmd.issue = (state_q == ST_RUN);
		cmd.acc_reset = (accept && item_mode == MODE_EMPTY) ||
			(state_q == ST_DRAIN && !sts.busy && emit_q);
		cmd.out_load = (state_q == ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			byte_q <= '0;
			clr_q <= '0;
			emit_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						byte_q <= '0;
						emit_q <= (item_mode == MODE_SCORE) && item_last;
						if (item_mode == MODE_LEARN || item_mode == MODE_SCORE)
							state_q <= ST_RUN;
						else if (item_mode == MODE_EMPTY)
							state_q <= ST_EMIT;
					end
				end
				ST_RUN: begin
					byte_q <= byte_q + 1'b1;
					if (&byte_q)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!sts.busy)
						state_q <= emit_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/bdrl_dp.sv
module bdrl_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bdrl_pkg::cmd_t                 cmd,
	output bdrl_pkg::sts_t                 sts,
	input  logic [1:0]                     item_mode,
	input  logic                           item_store_sel,
	input  logic [7:0]                     item_unit,
	input  logic [7:0]                     item_next_byte,
	input  logic signed [bdrl_pkg::GAIN_W-1:0] item_gain,
	input  logic                           item_also,
	input  logic                           item_last,
	input  logic [bdrl_pkg::RATE_W-1:0]    rate,
	input  logic                           two_stores,
	output logic [bdrl_pkg::NS_W-1:0]      next_score,
	output logic [bdrl_pkg::TOT_W-1:0]     total_score
);
	import bdrl_pkg::*;

	logic [W_W-1:0]   mem_a [0:(1 << ADDR_W)-1];
	logic [W_W-1:0]   mem_b [0:(1 << ADDR_W)-1];
	logic [ACC_W-1:0] acc_mem [0:ALPHABET-1];
	logic [ALPHABET-1:0] accv_q;

	logic [1:0]        mode_q;
	logic              sel_q, also_q, last_q, gneg_q;
	logic [UNIT_W-1:0] unit_q;
	logic [BYTE_W-1:0] nb_q;
	logic [GAIN_W-1:0] gmag_q;

	logic v_s1, v_s2, v_s3;
	logic [BYTE_W-1:0] b_s1, b_s2, b_s3;
	logic signed [W_W-1:0] wa_s1, wb_s1;
	logic signed [ACC_W-1:0] acc_s1;
	logic accv_s1;

	logic signed [W_W-1:0] w_s2, w_s3;
	logic [W_W-1:0] d1m_s2;
	logic neg_s2, neg_s3;
	logic signed [ACC_W-1:0] sum1_s2, sum_s3;
	logic signed [W_W-1:0] wb_s2;
	logic [NS_W-1:0] dwm_s3;

	logic [NS_W-1:0]  ns_q;
	logic [TOT_W-1:0] tot_q;
	logic [NS_W-1:0]  ns_out_q;
	logic [TOT_W-1:0] tot_out_q;

	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic signed [W_W:0] err;
	logic [W_W:0] errm;
	logic [W_W+RATE_W:0] p1;
	logic [W_W+GAIN_W-1:0] p2;
	logic signed [ACC_W:0] s1w, s2w;
	logic signed [ACC_W-1:0] acc_cur, sum1, sum2;
	logic signed [W_W+9:0] wn;
	logic [W_W-1:0] w_wr;
	logic learn_we, second;
	logic [NS_W-1:0] pos;
	logic [TOT_W:0] tsum;

	assign sts.busy = v_s1 || v_s2 || v_s3;
	assign rd_addr = {unit_q, cmd.byte_idx};
	assign wr_addr = cmd.clear_we ? cmd.clear_addr : {unit_q, b_s3};
	assign second = also_q && two_stores;
	assign next_score = ns_out_q;
	assign total_score = tot_out_q;

	// Weight stores: one read and one write per cycle each.
	always_ff @(posedge clk) begin
		if (cmd.clear_we || (learn_we && !sel_q))
			mem_a[wr_addr] <= cmd.clear_we ? '0 : w_wr;
		if (cmd.clear_we || (learn_we && sel_q))
			mem_b[wr_addr] <= cmd.clear_we ? '0 : w_wr;
		wa_s1 <= mem_a[rd_addr];
		wb_s1 <= mem_b[rd_addr];
		acc_s1 <= acc_mem[cmd.byte_idx];
		if (v_s3 && mode_q == MODE_SCORE && !last_q)
			acc_mem[b_s3] <= sum_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			accv_q <= '0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.acc_reset)
				accv_q <= '0;
			else if (v_s3 && mode_q == MODE_SCORE && !last_q)
				accv_q[b_s3] <= 1'b1;
		end
	end

	// Learn: error and first product. Score: first-store add.
	always_comb begin
		err = ((b_s1 == nb_q) ? W_ONE : (W_W + 1)'(signed'(0))) - (sel_q ? wb_s1 : wa_s1);
		errm = err[W_W] ? -err : err;
		p1 = (W_W + RATE_W + 1)'(errm) * (W_W + RATE_W + 1)'(rate);
		acc_cur = accv_s1 ? acc_s1 : '0;
		s1w = (ACC_W + 1)'(acc_cur) + (ACC_W + 1)'(wa_s1);
		sum1 = (s1w > (ACC_W + 1)'(signed'({1'b0, {(ACC_W-1){1'b1}}}))) ?
			{1'b0, {(ACC_W-1){1'b1}}} :
			(s1w < (ACC_W + 1)'(signed'({1'b1, {(ACC_W-1){1'b0}}}))) ?
			{1'b1, {(ACC_W-1){1'b0}}} : s1w[ACC_W-1:0];
	end

	// Learn: second product. Score: second-store add.
	always_comb begin
		p2 = (W_W + GAIN_W)'(d1m_s2) * (W_W + GAIN_W)'(gmag_q);
		s2w = (ACC_W + 1)'(sum1_s2) + (ACC_W + 1)'(wb_s2);
		if (!second)
			sum2 = sum1_s2;
		else if (s2w > (ACC_W + 1)'(signed'({1'b0, {(ACC_W-1){1'b1}}})))
			sum2 = {1'b0, {(ACC_W-1){1'b1}}};
		else if (s2w < (ACC_W + 1)'(signed'({1'b1, {(ACC_W-1){1'b0}}})))
			sum2 = {1'b1, {(ACC_W-1){1'b0}}};
		else
			sum2 = s2w[ACC_W-1:0];
	end

	// Learn: apply and clamp. Score: rectify and total.
	always_comb begin
		wn = (W_W + 10)'(w_s3) + (neg_s3 ? -(W_W + 10)'(dwm_s3) : (W_W + 10)'(dwm_s3));
		if (wn > W_MAX)
			w_wr = W_MAX[W_W-1:0];
		else if (wn < -W_MAX)
			w_wr = W_W'(-W_MAX);
		else
			w_wr = wn[W_W-1:0];
		learn_we = v_s3 && (mode_q == MODE_LEARN);
		pos = sum_s3[ACC_W-1] ? '0 : sum_s3[NS_W-1:0];
		tsum = (TOT_W + 1)'(tot_q) + (TOT_W + 1)'(pos);
	end

	always_ff @(posedge clk) begin
		b_s1 <= cmd.byte_idx;
		accv_s1 <= accv_q[cmd.byte_idx];
		b_s2 <= b_s1;
		w_s2 <= sel_q ? wb_s1 : wa_s1;
		d1m_s2 <= p1[W_W+RATE_W-1:RATE_W];
		neg_s2 <= err[W_W];
		sum1_s2 <= sum1;
		wb_s2 <= wb_s1;
		b_s3 <= b_s2;
		w_s3 <= w_s2;
		dwm_s3 <= p2[RATE_W+NS_W-1:RATE_W];
		neg_s3 <= neg_s2 ^ gneg_q;
		sum_s3 <= sum2;
		if (cmd.load) begin
			mode_q <= item_mode;
			sel_q <= item_store_sel;
			unit_q <= item_unit;
			nb_q <= item_next_byte;
			also_q <= item_also;
			last_q <= item_last;
			gneg_q <= item_gain[GAIN_W-1];
			gmag_q <= item_gain[GAIN_W-1] ? GAIN_W'(-item_gain) : item_gain;
			ns_q <= '0;
			tot_q <= '0;
		end else if (v_s3 && mode_q == MODE_SCORE && last_q) begin
			tot_q <= tsum[TOT_W] ? {TOT_W{1'b1}} : tsum[TOT_W-1:0];
			if (b_s3 == nb_q)
				ns_q <= pos;
		end
		if (cmd.out_load) begin
			ns_out_q <= ns_q;
			tot_out_q <= tot_q;
		end
	end
endmodule

>>> rtl/byte_delta_rule_learn_score.sv
// Learn and score items each sweep all 256 entries of a row, then drain the
// pipeline; score items marked last and empty positions then hand off a result.
// One item is in work at a time; the weight memories give one row entry per cycle.
// Mode 3 items are accepted and do nothing.
// After reset a clearing pass over all 65536 addresses zeroes both weight stores
// before the first item is accepted; configuration resets to rate 0, two stores on.
module byte_delta_rule_learn_score (
	input logic        clk,
	input logic        arst_n,
	bdrl_in_if.sink    item,
	bdrl_out_if.source result,
	bdrl_cfg_if.sink   cfg
);
	import bdrl_pkg::*;

	logic [RATE_W-1:0] learning_rate_q;
	logic              two_stores_q;
	cmd_t              cmd;
	sts_t              sts;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learning_rate_q <= '0;
			two_stores_q <= 1'b1;
		end else if (cfg.valid) begin
			if (cfg.index == REG_LEARNING_RATE)
				learning_rate_q <= cfg.data;
			else if (cfg.index == REG_TWO_STORES)
				two_stores_q <= cfg.data[0];
		end
	end

	bdrl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_mode  (item.mode),
		.item_last  (item.last),
		.item_ready (item.ready),
		.res_ready  (result.ready),
		.res_valid  (result.valid),
		.sts        (sts),
		.cmd        (cmd)
	);

	bdrl_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.item_mode      (item.mode),
		.item_store_sel (item.store_sel),
		.item_unit      (item.unit),
		.item_next_byte (item.next_byte),
		.item_gain      (item.local_gain),
		.item_also      (item.also_second),
		.item_last      (item.last),
		.rate           (learning_rate_q),
		.two_stores     (two_stores_q),
		.next_score     (result.next_score),
		.total_score    (result.total_score)
	);
endmodule
